// ----- src/ams_pkg.sv -----
// Shared types and constants for the admittance matrix stamper.
package ams_pkg;

    localparam int DEF_MAX_BUSES = 64;
    localparam logic [6:0] BUS_COUNT_RESET = 7'd64;

    // dividend is the 32-bit numerator placed above 34 fraction bits
    localparam int DVD_W = 66;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd66;
    localparam logic [30:0] Q_CAP = 31'h7FFF_FFFF;

    // half shunt: floor((p + 15625) / 31250), same as (2p + 31250) / 62500;
    // halve the biased product, then divide by 15625 through a 2^-45 reciprocal
    localparam logic [31:0] BSH_BIAS = 32'd15625;
    localparam logic [31:0] BSH_RECIP = 32'd2251799814;
    localparam int BSH_RSH = 45;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_STAMP = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ZERO_Z  = 2'd1,
        STAT_BAD_BUS = 2'd2
    } status_t;

    localparam logic REG_BUS_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_MUL1,
        ST_CHECK,
        ST_MUL2,
        ST_DEN,
        ST_DIVGO,
        ST_DIV,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RADDR,
        ST_RDATA,
        ST_DONE
    } state_t;

endpackage

// ----- src/admittance_matrix_stamper.sv -----
// Top level: bus admittance matrix builder with stamp, clear and read items.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  item     | item_valid / item_ready     | opcode, buses, r, x, b, length, row, col
//  result   | result_valid / result_ready | status, entry_real, entry_imag
//  config   | APB psel/penable/pwrite     | bus_count at byte address 0
//
// One item at a time. A stamp's length is set by the 66-step bit-serial
// dividers and four read-modify-write passes through the single RAM port.
// A read passes address and data states; a clear writes one entry per cycle.
// After reset a clearing pass over all MAX_BUSES*MAX_BUSES entries precedes any item.
// The next item is taken while a result waits; a stalled result stalls the one after.
module admittance_matrix_stamper #(
    parameter int MAX_BUSES = ams_pkg::DEF_MAX_BUSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [6:0]  bus_from,
    input  logic [6:0]  bus_to,
    input  logic [15:0] r_per_km,
    input  logic [15:0] x_per_km,
    input  logic [15:0] b_per_km,
    input  logic [15:0] length_km,
    input  logic [6:0]  read_row,
    input  logic [6:0]  read_col,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic signed [31:0] entry_real,
    output logic signed [31:0] entry_imag,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_BUSES);
    localparam int DEPTH = MAX_BUSES * MAX_BUSES;
    localparam int AW = $clog2(DEPTH);
    localparam int NBW = $clog2(MAX_BUSES + 1);
    localparam int CW = (NBW > 7) ? NBW : 7;

    function automatic logic [AW-1:0] ent_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
        ent_addr = AW'(r) * AW'(MAX_BUSES) + AW'(c);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] acc,
                                            input logic [32:0] d);
        logic [33:0] s;
        s = {{2{acc[31]}}, acc} + {d[32], d};
        if (!s[33] && (s[32] || s[31]))
            sat_add = 32'h7FFF_FFFF;
        else if (s[33] && !(s[32] && s[31]))
            sat_add = 32'h8000_0000;
        else
            sat_add = s[31:0];
    endfunction

    ams_pkg::state_t state_reg, state_next;

    logic [6:0]  bus_count_reg;
    logic [1:0]  op_reg;
    logic [6:0]  from_reg, to_reg, row_reg, col_reg;
    logic [15:0] r_reg, x_reg, b_reg, len_reg;
    logic [31:0] rr_reg, xr_reg, pb_reg;
    logic [30:0] rn_reg, xn_reg;
    logic        s_reg;
    logic [61:0] rsq_reg, xsq_reg;
    logic [62:0] den_reg;
    logic [30:0] g_reg, bq_reg;
    logic [17:0] bsh_reg;
    logic [1:0]  k_reg;
    logic [IW-1:0] ci_reg, cj_reg;
    logic [AW-1:0] init_reg;

    logic [1:0]  res_stat_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic        out_valid_reg;
    logic [1:0]  out_stat_reg;
    logic [31:0] out_re_reg, out_im_reg;

    logic [CW-1:0] n_eff, from_x, to_x, row_x, col_x;
    logic bad_stamp, bad_read, clear_last, init_last, out_load;
    logic [IW-1:0] from_idx, to_idx, row_idx, col_idx, rk, ck;
    logic [32:0] d_re, d_im;
    logic [63:0] bsh_prod;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wre, ram_wim, ram_rre, ram_rim;
    logic          div_start;
    logic          g_done, b_done;
    logic [30:0]   g_quo, b_quo;

    assign n_eff = (CW'(bus_count_reg) > CW'(MAX_BUSES)) ? CW'(MAX_BUSES)
                                                         : CW'(bus_count_reg);
    assign from_x = CW'(from_reg);
    assign to_x = CW'(to_reg);
    assign row_x = CW'(row_reg);
    assign col_x = CW'(col_reg);
    assign bad_stamp = (from_x == '0) || (to_x == '0) || (from_x > n_eff)
                       || (to_x > n_eff) || (from_x == to_x);
    assign bad_read = (row_x == '0) || (col_x == '0) || (row_x > n_eff) || (col_x > n_eff);
    assign from_idx = IW'(from_x - CW'(1));
    assign to_idx = IW'(to_x - CW'(1));
    assign row_idx = IW'(row_x - CW'(1));
    assign col_idx = IW'(col_x - CW'(1));
    assign clear_last = (CW'(ci_reg) + CW'(1) == n_eff) && (CW'(cj_reg) + CW'(1) == n_eff);
    assign init_last = (init_reg == AW'(DEPTH - 1));
    assign out_load = !out_valid_reg || result_ready;

    // pb_reg holds the halved biased product here
    assign bsh_prod = 64'(pb_reg) * 64'(ams_pkg::BSH_RECIP);

    // entry order: both diagonals, then both off-diagonals
    assign rk = k_reg[0] ? to_idx : from_idx;
    assign ck = (k_reg[0] ^ k_reg[1]) ? to_idx : from_idx;
    assign d_re = k_reg[1] ? -{2'b00, g_reg} : {2'b00, g_reg};
    assign d_im = k_reg[1] ? {2'b00, bq_reg} : ({15'd0, bsh_reg} - {2'b00, bq_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ams_pkg::ST_INIT:   if (init_last) state_next = ams_pkg::ST_IDLE;
            ams_pkg::ST_IDLE:   if (item_valid) state_next = ams_pkg::ST_DECODE;
            ams_pkg::ST_DECODE:
            begin
                unique case (ams_pkg::opcode_t'(op_reg))
                    ams_pkg::OP_CLEAR:
                        state_next = (n_eff == '0) ? ams_pkg::ST_DONE : ams_pkg::ST_CLEAR;
                    ams_pkg::OP_STAMP:
                        state_next = bad_stamp ? ams_pkg::ST_DONE : ams_pkg::ST_MUL1;
                    ams_pkg::OP_READ:
                        state_next = bad_read ? ams_pkg::ST_DONE : ams_pkg::ST_RADDR;
                    default: state_next = ams_pkg::ST_DONE;
                endcase
            end
            ams_pkg::ST_CLEAR:  if (clear_last) state_next = ams_pkg::ST_DONE;
            ams_pkg::ST_MUL1:   state_next = ams_pkg::ST_CHECK;
            ams_pkg::ST_CHECK:
                state_next = (rr_reg == '0 && xr_reg == '0) ? ams_pkg::ST_DONE
                                                           : ams_pkg::ST_MUL2;
            ams_pkg::ST_MUL2:   state_next = ams_pkg::ST_DEN;
            ams_pkg::ST_DEN:    state_next = ams_pkg::ST_DIVGO;
            ams_pkg::ST_DIVGO:  state_next = ams_pkg::ST_DIV;
            ams_pkg::ST_DIV:    if (g_done) state_next = ams_pkg::ST_RMW_RD;
            ams_pkg::ST_RMW_RD: state_next = ams_pkg::ST_RMW_WR;
            ams_pkg::ST_RMW_WR:
                state_next = (k_reg == 2'd3) ? ams_pkg::ST_DONE : ams_pkg::ST_RMW_RD;
            ams_pkg::ST_RADDR:  state_next = ams_pkg::ST_RDATA;
            ams_pkg::ST_RDATA:  state_next = ams_pkg::ST_DONE;
            ams_pkg::ST_DONE:   if (out_load) state_next = ams_pkg::ST_IDLE;
            default:            state_next = ams_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_ready = 1'b0;
        ram_we = 1'b0;
        ram_addr = ent_addr(rk, ck);
        ram_wre = '0;
        ram_wim = '0;
        div_start = 1'b0;
        unique case (state_reg)
            ams_pkg::ST_INIT:
            begin
                ram_we = 1'b1;
                ram_addr = init_reg;
            end
            ams_pkg::ST_IDLE:   item_ready = 1'b1;
            ams_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = ent_addr(ci_reg, cj_reg);
            end
            ams_pkg::ST_DIVGO:  div_start = 1'b1;
            ams_pkg::ST_RMW_WR:
            begin
                ram_we = 1'b1;
                ram_wre = sat_add(ram_rre, d_re);
                ram_wim = sat_add(ram_rim, d_im);
            end
            ams_pkg::ST_RADDR:  ram_addr = ent_addr(row_idx, col_idx);
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ams_pkg::ST_INIT;
            bus_count_reg <= ams_pkg::BUS_COUNT_RESET;
            out_valid_reg <= 1'b0;
            init_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr[2] == ams_pkg::REG_BUS_COUNT)
            begin
                bus_count_reg <= pwdata[6:0];
            end
            if (state_reg == ams_pkg::ST_INIT)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (state_reg == ams_pkg::ST_DONE && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ams_pkg::ST_IDLE && item_valid)
        begin
            op_reg <= opcode;
            from_reg <= bus_from;
            to_reg <= bus_to;
            r_reg <= r_per_km;
            x_reg <= x_per_km;
            b_reg <= b_per_km;
            len_reg <= length_km;
            row_reg <= read_row;
            col_reg <= read_col;
            res_stat_reg <= ams_pkg::STAT_OK;
            res_re_reg <= '0;
            res_im_reg <= '0;
            ci_reg <= '0;
            cj_reg <= '0;
            k_reg <= '0;
        end
        unique case (state_reg)
            ams_pkg::ST_DECODE:
            begin
                if ((op_reg == ams_pkg::OP_STAMP && bad_stamp)
                    || (op_reg == ams_pkg::OP_READ && bad_read))
                begin
                    res_stat_reg <= ams_pkg::STAT_BAD_BUS;
                end
            end
            ams_pkg::ST_CLEAR:
            begin
                if (CW'(cj_reg) + CW'(1) == n_eff)
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_reg + 1'b1;
                end
                else
                begin
                    cj_reg <= cj_reg + 1'b1;
                end
            end
            ams_pkg::ST_MUL1:
            begin
                rr_reg <= 32'(r_reg) * 32'(len_reg);
                xr_reg <= 32'(x_reg) * 32'(len_reg);
                pb_reg <= 32'(b_reg) * 32'(len_reg);
            end
            ams_pkg::ST_CHECK:
            begin
                if (rr_reg == '0 && xr_reg == '0)
                begin
                    res_stat_reg <= ams_pkg::STAT_ZERO_Z;
                end
                // one shift brings both below 2^31
                s_reg <= rr_reg[31] | xr_reg[31];
                rn_reg <= (rr_reg[31] | xr_reg[31]) ? rr_reg[31:1] : rr_reg[30:0];
                xn_reg <= (rr_reg[31] | xr_reg[31]) ? xr_reg[31:1] : xr_reg[30:0];
                pb_reg <= (pb_reg + ams_pkg::BSH_BIAS) >> 1;
            end
            ams_pkg::ST_MUL2:
            begin
                rsq_reg <= 62'(rn_reg) * 62'(rn_reg);
                xsq_reg <= 62'(xn_reg) * 62'(xn_reg);
                bsh_reg <= bsh_prod[ams_pkg::BSH_RSH +: 18];
            end
            ams_pkg::ST_DEN:    den_reg <= 63'(rsq_reg) + 63'(xsq_reg);
            ams_pkg::ST_DIV:
            begin
                if (g_done)
                begin
                    g_reg <= g_quo;
                    bq_reg <= b_quo;
                end
            end
            ams_pkg::ST_RMW_WR: k_reg <= k_reg + 1'b1;
            ams_pkg::ST_RDATA:
            begin
                res_re_reg <= ram_rre;
                res_im_reg <= ram_rim;
            end
            ams_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_stat_reg <= res_stat_reg;
                    out_re_reg <= res_re_reg;
                    out_im_reg <= res_im_reg;
                end
            end
            default: ;
        endcase
    end

    ams_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_re (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wre),
        .rdata (ram_rre)
    );

    ams_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_im (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wim),
        .rdata (ram_rim)
    );

    ams_div u_div_g (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num ({1'b0, rn_reg}), .den (den_reg), .sh ({5'd0, s_reg}),
        .done (g_done), .quo (g_quo)
    );

    ams_div u_div_b (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num ({1'b0, xn_reg}), .den (den_reg), .sh ({5'd0, s_reg}),
        .done (b_done), .quo (b_quo)
    );

    assign result_valid = out_valid_reg;
    assign status = out_stat_reg;
    assign entry_real = out_re_reg;
    assign entry_imag = out_im_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ams_pkg::REG_BUS_COUNT) ? {25'd0, bus_count_reg} : '0;

`ifndef SYNTHESIS
    a_dividers_together: assert property (@(posedge clk) disable iff (!rst_n)
        g_done |-> b_done && state_reg == ams_pkg::ST_DIV)
        else $error("dividers out of step");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ams_pkg::ST_IDLE |-> !ram_we)
        else $error("RAM write while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ams_pkg::ST_DONE)
        else $error("result raised outside done state");

    a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ams_pkg::ST_INIT |-> !item_ready)
        else $error("item taken during clearing pass");
`endif

endmodule

// ----- src/ams_ram.sv -----
// Generic single-port RAM with registered read.
module ams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/ams_div.sv -----
// Restoring divider: floor(num * 2^(34-sh) / den), capped at 2^31-1, one bit a cycle.
module ams_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [62:0] den,
    input  logic [5:0]  sh,
    output logic        done,
    output logic [30:0] quo
);

    logic [ams_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [62:0]                   rem_reg, rem_next;
    logic [30:0]                   q_reg, q_next;
    logic                          ovf_reg, ovf_next;
    logic [ams_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [63:0]                   rem_sh;
    logic                          ge;

    assign rem_sh = {rem_reg, dvd_reg[ams_pkg::DVD_W-1]};
    assign ge = (rem_sh >= {1'b0, den});

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = {num, 34'd0} >> sh;
            rem_next = '0;
            q_next = '0;
            ovf_next = 1'b0;
            cnt_next = ams_pkg::DIV_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[ams_pkg::DVD_W-2:0], 1'b0};
            rem_next = ge ? 63'(rem_sh - {1'b0, den}) : rem_sh[62:0];
            // a quotient bit pushed past bit 30 means the result is capped
            ovf_next = ovf_reg | q_reg[30];
            q_next = {q_reg[29:0], ge};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quo = ovf_reg ? ams_pkg::Q_CAP : q_reg;

`ifndef SYNTHESIS
    a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cnt_reg) == 7'd1)
        else $error("divider done without final step");
`endif

endmodule
